FILE: design/rllbe_pkg.sv
// Shared types and constants for the run-length literal byte encoder.
// No dependencies; every other design file imports this package.
package rllbe_pkg;

	// Literal store geometry
	localparam int LIT_DEPTH = 128;
	localparam int LIT_AW = $clog2(LIT_DEPTH);

	// Default output word size in bytes
	localparam int OUT_WORD_BYTES_DEF = 8;

	// Input function codes
	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_DATA = 2'd1;
	localparam logic [1:0] FUNC_END = 2'd2;

	// Output code bytes
	localparam logic [7:0] CODE_LIT = 8'h80;
	localparam logic [7:0] CODE_ZERO = 8'h40;
	localparam logic [7:0] CODE_RUN = 8'h20;
	localparam logic [7:0] CODE_FF = 8'h10;
	localparam logic [7:0] CODE_PAT_FF = 8'h01;
	localparam logic [7:0] CODE_PAT = 8'h02;
	localparam logic [7:0] CODE_ZERO4 = 8'h43;
	localparam logic [7:0] CODE_ZCHUNK = 8'h7F;
	localparam logic [7:0] CODE_RCHUNK = 8'h3F;
	localparam logic [7:0] CODE_EOR = 8'h00;
	localparam logic [7:0] BYTE_FF = 8'hFF;

	// Byte push request from sequencer to packer
	typedef struct packed {
		logic       push;
		logic [7:0] data;
		logic       fin;
	} pk_req_t;

	// Packer status back to sequencer
	typedef struct packed {
		logic byte_ready;
		logic fin_ready;
	} pk_stat_t;

endpackage

FILE: design/rllbe_lit_mem.sv
// Literal byte store: one write port, one read port, registered read data.
// Depends on rllbe_pkg for the store geometry.
module rllbe_lit_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [rllbe_pkg::LIT_AW-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic [rllbe_pkg::LIT_AW-1:0] raddr,
	output logic [7:0]                 rdata
);
	import rllbe_pkg::*;

	logic [7:0] mem [LIT_DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: design/rllbe_pack.sv
// Byte packer: gathers code bytes into output words, marks the final word.
// Depends on rllbe_pkg for the request and status structs.
module rllbe_pack #(
	parameter int OUT_WORD_BYTES = rllbe_pkg::OUT_WORD_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rllbe_pkg::pk_req_t  req,
	output rllbe_pkg::pk_stat_t stat,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         out_bytes,
	output logic [3:0]          byte_count,
	output logic                last
);
	import rllbe_pkg::*;

	logic [63:0] acc_q;
	logic [3:0]  acc_n_q;
	logic        out_free;
	logic        acc_full;
	logic [63:0] ins;

	assign out_free = !out_valid || out_ready;
	assign acc_full = (acc_n_q == 4'(OUT_WORD_BYTES));
	assign stat.byte_ready = !acc_full || out_free;
	assign stat.fin_ready = (acc_n_q == 4'd0) || out_free;
	assign ins = {req.data, 56'h0} >> {acc_n_q[2:0], 3'b000};

	// Hold payload registers without reset
	always_ff @(posedge clk) begin
		if (req.push && stat.byte_ready && acc_full) begin
			out_bytes <= acc_q;
			byte_count <= acc_n_q;
			last <= 1'b0;
		end else if (req.fin && stat.fin_ready && acc_n_q != 4'd0) begin
			out_bytes <= acc_q;
			byte_count <= acc_n_q;
			last <= 1'b1;
		end
	end

	// Advance accumulator and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			acc_n_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (req.push && stat.byte_ready) begin
				if (acc_full) begin
					out_valid <= 1'b1;
					acc_q <= {req.data, 56'h0};
					acc_n_q <= 4'd1;
				end else begin
					acc_q <= acc_q | ins;
					acc_n_q <= acc_n_q + 4'd1;
				end
			end else if (req.fin && stat.fin_ready && acc_n_q != 4'd0) begin
				out_valid <= 1'b1;
				acc_q <= '0;
				acc_n_q <= '0;
			end
		end
	end

endmodule

FILE: design/rllbe_ctrl.sv
// Encoding sequencer: run, lookahead and literal state, code byte emission.
// Depends on rllbe_pkg; drives rllbe_lit_mem and rllbe_pack.
module rllbe_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic [7:0]                   data_byte,
	input  logic signed [31:0]           range_offset,
	output logic                         mem_we,
	output logic [rllbe_pkg::LIT_AW-1:0] mem_waddr,
	output logic [7:0]                   mem_wdata,
	output logic [rllbe_pkg::LIT_AW-1:0] mem_raddr,
	input  logic [7:0]                   mem_rdata,
	output rllbe_pkg::pk_req_t           pk_req,
	input  rllbe_pkg::pk_stat_t          pk_stat
);
	import rllbe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_STEP, S_NEXT, S_RESOLVE, S_ENDCHK, S_ENDLIT, S_ENDZ,
		S_EMIT, S_LRD, S_LWR, S_FIN
	} state_t;

	state_t            state_q, ret_q, lret_q;
	logic [31:0]       em_data_q;
	logic [2:0]        em_cnt_q;
	logic [7:0]        cur_q;
	logic [7:0]        lit_cnt_q;
	logic [7:0]        run_val_q;
	logic [6:0]        run_cnt_q;
	logic              chunk_q;
	logic [7:0]        la_q [5];
	logic [2:0]        la_cnt_q;
	logic [2:0]        rp_q, rn_q;
	logic              end_q;
	logic [LIT_AW-1:0] rd_ptr_q;

	// Close-run code bytes
	logic [15:0] cr_bytes;
	logic [2:0]  cr_n;
	logic        cr_lit;
	logic [7:0]  rm1;
	// Step decisions
	logic        active;
	logic [6:0]  nc;
	logic [6:0]  limit;
	logic        la_entry;
	// Resolve decisions
	logic        decide;
	logic        take;
	logic [7:0]  lit_hdr;

	always_comb begin
		rm1 = {1'b0, run_cnt_q - 7'd1};
		cr_bytes = '0;
		cr_n = 3'd0;
		cr_lit = 1'b0;
		if (run_cnt_q >= 7'd2) begin
			if (run_val_q == 8'h00) begin
				cr_bytes = {CODE_ZERO | rm1, 8'h00};
				cr_n = 3'd1;
			end else if (run_val_q == BYTE_FF && !chunk_q && run_cnt_q <= 7'd16) begin
				cr_bytes = {CODE_FF | rm1, 8'h00};
				cr_n = 3'd1;
			end else begin
				cr_bytes = {CODE_RUN | rm1, run_val_q};
				cr_n = 3'd2;
			end
		end else if (run_cnt_q == 7'd1) begin
			cr_lit = 1'b1;
		end
	end

	always_comb begin
		active = (run_cnt_q != 7'd0) || chunk_q;
		nc = run_cnt_q + 7'd1;
		limit = (run_val_q == 8'h00) ? 7'd64 : 7'd32;
		la_entry = active && run_val_q == 8'h00 && run_cnt_q == 7'd4 && !chunk_q
			&& cur_q == BYTE_FF;
		lit_hdr = CODE_LIT | {1'b0, 7'(lit_cnt_q - 8'd1)};
	end

	// Pattern decision over the held bytes
	always_comb begin
		decide = 1'b1;
		take = 1'b0;
		if (la_cnt_q < 3'd4) begin
			decide = end_q;
		end else if (la_q[1] == 8'h00 && la_q[2] == 8'h00 && la_q[3] == 8'h00) begin
			take = 1'b0;
		end else if (la_q[1] == BYTE_FF && la_q[2] == BYTE_FF && la_q[3] == BYTE_FF) begin
			take = 1'b0;
		end else if (la_q[1] == la_q[2] && la_q[2] == la_q[3]) begin
			decide = !(la_cnt_q == 3'd4 && !end_q);
			take = !(la_cnt_q >= 3'd5 && la_q[4] == la_q[3]);
		end else begin
			take = 1'b1;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign mem_raddr = rd_ptr_q;
	assign pk_req.push = (state_q == S_EMIT && em_cnt_q != 3'd0) || state_q == S_LWR;
	assign pk_req.data = (state_q == S_LWR) ? mem_rdata : em_data_q[31:24];
	assign pk_req.fin = (state_q == S_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			lret_q <= S_IDLE;
			em_data_q <= '0;
			em_cnt_q <= '0;
			cur_q <= '0;
			lit_cnt_q <= '0;
			run_val_q <= '0;
			run_cnt_q <= '0;
			chunk_q <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				la_q[i] <= '0;
			end
			la_cnt_q <= '0;
			rp_q <= '0;
			rn_q <= '0;
			end_q <= 1'b0;
			rd_ptr_q <= '0;
			mem_we <= 1'b0;
			mem_waddr <= '0;
			mem_wdata <= '0;
		end else begin
			mem_we <= 1'b0;
			case (state_q)
				// Take one input word
				S_IDLE: begin
					if (in_valid) begin
						case (func)
							FUNC_START: begin
								lit_cnt_q <= '0;
								run_val_q <= '0;
								run_cnt_q <= '0;
								chunk_q <= 1'b0;
								la_cnt_q <= '0;
								em_data_q <= range_offset;
								em_cnt_q <= 3'd4;
								ret_q <= S_FIN;
								state_q <= S_EMIT;
							end
							FUNC_DATA: begin
								cur_q <= data_byte;
								state_q <= S_STEP;
							end
							FUNC_END: begin
								end_q <= 1'b1;
								state_q <= S_ENDCHK;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				// Process one byte against run and lookahead state
				S_STEP: begin
					if (la_cnt_q != 3'd0) begin
						if (la_cnt_q < 3'd5) begin
							la_q[la_cnt_q] <= cur_q;
						end
						la_cnt_q <= la_cnt_q + 3'd1;
						state_q <= S_RESOLVE;
					end else if (active && cur_q == run_val_q) begin
						if (nc == 7'd2 && lit_cnt_q != 8'd0) begin
							run_cnt_q <= nc;
							em_data_q <= {lit_hdr, 24'h0};
							em_cnt_q <= 3'd1;
							rd_ptr_q <= '0;
							ret_q <= S_LRD;
							lret_q <= S_NEXT;
							state_q <= S_EMIT;
						end else if (nc >= limit) begin
							if (run_val_q == 8'h00) begin
								em_data_q <= {CODE_ZCHUNK, 24'h0};
								em_cnt_q <= 3'd1;
							end else begin
								em_data_q <= {CODE_RCHUNK, run_val_q, 16'h0};
								em_cnt_q <= 3'd2;
							end
							run_cnt_q <= '0;
							chunk_q <= 1'b1;
							ret_q <= S_NEXT;
							state_q <= S_EMIT;
						end else begin
							run_cnt_q <= nc;
							state_q <= S_NEXT;
						end
					end else if (la_entry) begin
						run_cnt_q <= '0;
						la_q[0] <= cur_q;
						la_cnt_q <= 3'd1;
						state_q <= S_NEXT;
					end else begin
						run_val_q <= cur_q;
						run_cnt_q <= 7'd1;
						chunk_q <= 1'b0;
						state_q <= S_EMIT;
						em_data_q <= {cr_bytes, 16'h0};
						em_cnt_q <= cr_n;
						ret_q <= S_NEXT;
						if (cr_lit) begin
							mem_we <= 1'b1;
							mem_waddr <= lit_cnt_q[LIT_AW-1:0];
							mem_wdata <= run_val_q;
							lit_cnt_q <= lit_cnt_q + 8'd1;
							if (lit_cnt_q == 8'(LIT_DEPTH - 1)) begin
								em_data_q <= {CODE_LIT | 8'(LIT_DEPTH - 1), 24'h0};
								em_cnt_q <= 3'd1;
								rd_ptr_q <= '0;
								ret_q <= S_LRD;
								lret_q <= S_NEXT;
							end
						end
					end
				end
				// Replay held bytes or finish the word
				S_NEXT: begin
					if (rp_q != rn_q) begin
						cur_q <= la_q[rp_q];
						rp_q <= rp_q + 3'd1;
						state_q <= S_STEP;
					end else begin
						rp_q <= '0;
						rn_q <= '0;
						state_q <= end_q ? S_ENDCHK : S_FIN;
					end
				end
				// Settle a pending pattern decision
				S_RESOLVE: begin
					if (!decide) begin
						state_q <= S_NEXT;
					end else begin
						la_cnt_q <= '0;
						ret_q <= S_NEXT;
						state_q <= S_EMIT;
						if (take) begin
							if (la_q[1] == BYTE_FF) begin
								em_data_q <= {CODE_PAT_FF, la_q[2], la_q[3], 8'h00};
								em_cnt_q <= 3'd3;
							end else begin
								em_data_q <= {CODE_PAT, la_q[1], la_q[2], la_q[3]};
								em_cnt_q <= 3'd4;
							end
							rp_q <= 3'd4;
							rn_q <= (la_cnt_q >= 3'd5) ? 3'd5 : 3'd4;
						end else begin
							em_data_q <= {CODE_ZERO4, 24'h0};
							em_cnt_q <= 3'd1;
							rp_q <= '0;
							rn_q <= la_cnt_q;
						end
					end
				end
				// End of range: drain lookahead, then close the run
				S_ENDCHK: begin
					if (la_cnt_q != 3'd0) begin
						state_q <= S_RESOLVE;
					end else begin
						run_cnt_q <= '0;
						chunk_q <= 1'b0;
						em_data_q <= {cr_bytes, 16'h0};
						em_cnt_q <= cr_n;
						ret_q <= S_ENDLIT;
						state_q <= S_EMIT;
						if (cr_lit) begin
							mem_we <= 1'b1;
							mem_waddr <= lit_cnt_q[LIT_AW-1:0];
							mem_wdata <= run_val_q;
							lit_cnt_q <= lit_cnt_q + 8'd1;
						end
					end
				end
				// Flush pending literal bytes
				S_ENDLIT: begin
					if (lit_cnt_q != 8'd0) begin
						em_data_q <= {lit_hdr, 24'h0};
						em_cnt_q <= 3'd1;
						rd_ptr_q <= '0;
						ret_q <= S_LRD;
						lret_q <= S_ENDZ;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_ENDZ;
					end
				end
				// Write end marker and clear range state
				S_ENDZ: begin
					em_data_q <= {CODE_EOR, 24'h0};
					em_cnt_q <= 3'd1;
					ret_q <= S_FIN;
					state_q <= S_EMIT;
					end_q <= 1'b0;
					lit_cnt_q <= '0;
					run_val_q <= '0;
					run_cnt_q <= '0;
					chunk_q <= 1'b0;
					la_cnt_q <= '0;
				end
				// Shift out short code sequences
				S_EMIT: begin
					if (em_cnt_q == 3'd0) begin
						state_q <= ret_q;
					end else if (pk_stat.byte_ready) begin
						em_data_q <= {em_data_q[23:0], 8'h00};
						em_cnt_q <= em_cnt_q - 3'd1;
					end
				end
				// Literal read: address issued, data next cycle
				S_LRD: begin
					state_q <= S_LWR;
				end
				S_LWR: begin
					if (pk_stat.byte_ready) begin
						rd_ptr_q <= rd_ptr_q + LIT_AW'(1);
						if ({1'b0, rd_ptr_q} == 8'(lit_cnt_q - 8'd1)) begin
							lit_cnt_q <= '0;
							state_q <= lret_q;
						end else begin
							state_q <= S_LRD;
						end
					end
				end
				// Close the packer word for this item
				S_FIN: begin
					if (pk_stat.fin_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: design/run_length_literal_byte_encoder_core.sv
// Run-length literal byte encoder: top level.
// Depends on rllbe_pkg, rllbe_lit_mem, rllbe_pack and rllbe_ctrl.
//
// Usage: the input channel (in_valid/in_ready) takes one word per item:
// func selects start of range (four header bytes from range_offset), a data
// byte, or end of range (flush pending codes and write the end marker).
// The output channel (out_valid/out_ready) delivers packed code bytes,
// first byte in the top bits, byte_count valid bytes, last set on the final
// word caused by an item. An item that causes no bytes gives no word.
// Throughput: one item in flight. A data byte that only extends a run passes
// through the step, next and finish states before the next acceptance. The
// emitter shifts out code bytes while the packer can take them; each literal
// byte flushed from the store is read, then pushed, up to 128 bytes in a
// full flush. The store's single registered read port sets the flush rate.
// The packer holds one finished word in its output register, so the next
// item is accepted while that word waits; if the receiver stalls longer,
// the packer fills and the sequencer waits on it.
// Reset clears all control state; the literal store is not cleared and
// holds no valid data until written.
module run_length_literal_byte_encoder_core #(
	parameter int OUT_WORD_BYTES = rllbe_pkg::OUT_WORD_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [7:0]         data_byte,
	input  logic signed [31:0] range_offset,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        out_bytes,
	output logic [3:0]         byte_count,
	output logic               last
);
	import rllbe_pkg::*;

	logic              mem_we;
	logic [LIT_AW-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic [LIT_AW-1:0] mem_raddr;
	logic [7:0]        mem_rdata;
	pk_req_t           pk_req;
	pk_stat_t          pk_stat;

	rllbe_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.data_byte    (data_byte),
		.range_offset (range_offset),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.pk_req       (pk_req),
		.pk_stat      (pk_stat)
	);

	rllbe_lit_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rllbe_pack #(
		.OUT_WORD_BYTES (OUT_WORD_BYTES)
	) u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (pk_req),
		.stat       (pk_stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_bytes  (out_bytes),
		.byte_count (byte_count),
		.last       (last)
	);

endmodule

FILE: test/testbench.sv
// Self-checking testbench for run_length_literal_byte_encoder_core.
// Depends on rllbe_pkg and the encoder RTL; holds its own encoder model.
module testbench;
	import rllbe_pkg::*;

	localparam int WB = 8;

	typedef struct {
		logic [63:0] bytes;
		logic [3:0]  cnt;
		logic        fin;
	} word_t;

	typedef struct {
		logic [1:0]         fn;
		logic [7:0]         db;
		logic signed [31:0] off;
		logic               chk;   // typed expectation present
		logic [63:0]        xbytes;
		logic [3:0]         xcnt;
	} row_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         func = '0;
	logic [7:0]         data_byte = '0;
	logic signed [31:0] range_offset = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [63:0]        out_bytes;
	logic [3:0]         byte_count;
	logic               last;

	int errors = 0;
	int rx_stall_on = 1;

	// encoder model state
	logic [7:0] lit_mem [128];
	int unsigned lit_n;
	logic [7:0] rv;
	int unsigned rn;
	bit         rchunk;
	logic [7:0] la [5];
	int unsigned la_n;
	logic [7:0] code_q [$];
	word_t      expected_words [$];

	run_length_literal_byte_encoder_core #(.OUT_WORD_BYTES(WB)) DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	task automatic put_code(input logic [7:0] b);
		code_q.push_back(b);
	endtask

	task automatic flush_lit();
		if (lit_n == 0)
			return;
		put_code(CODE_LIT | 8'(lit_n - 1));
		for (int i = 0; i < lit_n; i++)
			put_code(lit_mem[i]);
		lit_n = 0;
	endtask

	task automatic add_lit(input logic [7:0] b);
		lit_mem[lit_n] = b;
		lit_n++;
		if (lit_n >= 128)
			flush_lit();
	endtask

	task automatic close_run();
		if (rn >= 2) begin
			if (rv == 0)
				put_code(CODE_ZERO | 8'(rn - 1));
			else if (rv == BYTE_FF && !rchunk && rn <= 16)
				put_code(CODE_FF | 8'(rn - 1));
			else begin
				put_code(CODE_RUN | 8'(rn - 1));
				put_code(rv);
			end
		end else if (rn == 1) begin
			add_lit(rv);
		end
		rn = 0;
		rchunk = 0;
	endtask

	task automatic clear_state();
		lit_n = 0;
		rv = 0;
		rn = 0;
		rchunk = 0;
		la_n = 0;
	endtask

	// settle the zero-four pattern decision
	task automatic decide_pattern(input bit at_end);
		int unsigned n;
		logic [7:0] t [5];
		bit take;
		n = la_n;
		t = la;
		take = 0;
		if (n < 4) begin
			if (!at_end)
				return;
		end else if (t[1] == 0 && t[2] == 0 && t[3] == 0) begin
			take = 0;
		end else if (t[1] == BYTE_FF && t[2] == BYTE_FF && t[3] == BYTE_FF) begin
			take = 0;
		end else if (t[1] == t[2] && t[2] == t[3]) begin
			if (n == 4 && !at_end)
				return;
			take = !(n >= 5 && t[4] == t[3]);
		end else begin
			take = 1;
		end
		la_n = 0;
		if (take) begin
			if (t[1] == BYTE_FF) begin
				put_code(CODE_PAT_FF);
			end else begin
				put_code(CODE_PAT);
				put_code(t[1]);
			end
			put_code(t[2]);
			put_code(t[3]);
			if (n >= 5)
				encode_byte(t[4]);
		end else begin
			put_code(CODE_ZERO4);
			if (n > 5)
				n = 5;
			for (int i = 0; i < n; i++)
				encode_byte(t[i]);
		end
	endtask

	task automatic encode_byte(input logic [7:0] b);
		bit act;
		int unsigned lim;
		act = (rn != 0) || rchunk;
		if (la_n != 0) begin
			if (la_n < 5)
				la[la_n] = b;
			la_n++;
			decide_pattern(0);
			return;
		end
		if (act && b == rv) begin
			lim = (rv == 0) ? 64 : 32;
			rn++;
			if (rn == 2)
				flush_lit();
			if (rn >= lim) begin
				if (rv == 0) begin
					put_code(CODE_ZCHUNK);
				end else begin
					put_code(CODE_RCHUNK);
					put_code(rv);
				end
				rn = 0;
				rchunk = 1;
			end
			return;
		end
		if (act && rv == 0 && rn == 4 && !rchunk && b == BYTE_FF) begin
			rn = 0;
			la[0] = b;
			la_n = 1;
			return;
		end
		close_run();
		rv = b;
		rn = 1;
		rchunk = 0;
	endtask

	// run one input word through the model and pack its codes into words
	task automatic predict_words(input logic [1:0] fn, input logic [7:0] db,
			input logic [31:0] off);
		word_t w;
		int c;
		code_q.delete();
		case (fn)
			FUNC_START: begin
				clear_state();
				for (int i = 3; i >= 0; i--)
					put_code(off[8*i +: 8]);
			end
			FUNC_DATA: encode_byte(db);
			FUNC_END: begin
				while (la_n != 0)
					decide_pattern(1);
				close_run();
				flush_lit();
				put_code(CODE_EOR);
				clear_state();
			end
			default: ;
		endcase
		while (code_q.size() > 0) begin
			c = (code_q.size() > WB) ? WB : code_q.size();
			w.bytes = '0;
			for (int i = 0; i < c; i++)
				w.bytes[56 - 8*i +: 8] = code_q.pop_front();
			w.cnt = 4'(c);
			w.fin = (code_q.size() == 0);
			expected_words.push_back(w);
		end
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// send one word and queue its expected output; hold valid across back-to-back words
	task automatic send_word(input logic [1:0] fn, input logic [7:0] db,
			input logic [31:0] off, input bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		predict_words(fn, db, off);
		in_valid <= 1;
		func <= fn;
		data_byte <= db;
		range_offset <= off;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// check outputs against the oldest expectation
	always @(posedge clk) begin
		word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word %h", out_bytes);
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (out_bytes !== e.bytes) begin
					$error("out_bytes exp %h got %h", e.bytes, out_bytes);
					errors++;
				end
				if (byte_count !== e.cnt) begin
					$error("byte_count exp %0d got %0d", e.cnt, byte_count);
					errors++;
				end
				if (last !== e.fin) begin
					$error("last exp %0d got %0d", e.fin, last);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (rx_stall_on) begin
				g = gap_len();
				if (g > 0) begin
					out_ready <= 0;
					repeat (g - 1) @(posedge clk);
					@(posedge clk);
				end
			end
			out_ready <= 1;
		end
	end

	// byte source shaped to hit runs, zero-four patterns and literals
	task automatic send_random_range(input int len);
		int kind;
		logic [7:0] v;
		send_word(FUNC_START, 8'($urandom), -$signed(32'($urandom_range(0, 32'h7FFFFFFF))), 1);
		for (int i = 0; i < len; ) begin
			kind = $urandom_range(0, 9);
			if (kind < 3) begin
				send_word(FUNC_DATA, 8'($urandom), 32'($urandom), 1);
				i++;
			end else if (kind < 6) begin
				v = ($urandom_range(0, 2) == 0) ? 8'h00 :
					($urandom_range(0, 1) ? BYTE_FF : 8'($urandom));
				repeat ($urandom_range(2, 8)) begin
					send_word(FUNC_DATA, v, 0, 1);
					i++;
				end
			end else if (kind < 8) begin
				repeat (4) send_word(FUNC_DATA, 8'h00, 0, 1);
				send_word(FUNC_DATA, BYTE_FF, 0, 1);
				v = 8'($urandom);
				repeat ($urandom_range(1, 4)) begin
					send_word(FUNC_DATA, $urandom_range(0, 1) ? v : 8'($urandom), 0, 1);
					i++;
				end
				i += 5;
			end else if (kind == 8) begin
				send_word(2'd3, 8'($urandom), 32'($urandom), 1);
			end else begin
				send_word(FUNC_DATA, 8'h00, 0, 1);
				i++;
			end
		end
		if ($urandom_range(0, 9) != 0)
			send_word(FUNC_END, 8'($urandom), 0, 1);
	endtask

	initial begin
		row_t dir [$];
		row_t r;
		clear_state();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows: headers, extremes, ignored code, unopened end
		dir.push_back('{FUNC_END, 8'h00, 32'sh0, 1'b1, 64'h00 << 56, 4'd1});
		dir.push_back('{FUNC_START, 8'h00, 32'sh80000000, 1'b1, 64'h80000000 << 32, 4'd4});
		dir.push_back('{FUNC_START, 8'h00, 32'sh00000000, 1'b1, 64'h0, 4'd4});
		dir.push_back('{FUNC_START, 8'hFF, 32'shFFFFFFFF, 1'b1, 64'hFFFFFFFF << 32, 4'd4});
		dir.push_back('{2'd3, 8'hFF, 32'sh12345678, 1'b0, 64'h0, 4'd0});
		dir.push_back('{FUNC_DATA, 8'hFF, 32'sh0, 1'b0, 64'h0, 4'd0});
		dir.push_back('{FUNC_DATA, 8'h00, 32'sh0, 1'b0, 64'h0, 4'd0});
		dir.push_back('{FUNC_DATA, 8'hA5, 32'sh0, 1'b0, 64'h0, 4'd0});
		dir.push_back('{FUNC_END, 8'h00, 32'sh0, 1'b0, 64'h0, 4'd0});
		// zero four, FF, then two-byte pattern form and three-byte form
		for (int k = 0; k < 2; k++) begin
			for (int i = 0; i < 4; i++)
				dir.push_back('{FUNC_DATA, 8'h00, 32'sh0, 1'b0, 64'h0, 4'd0});
			dir.push_back('{FUNC_DATA, BYTE_FF, 32'sh0, 1'b0, 64'h0, 4'd0});
			dir.push_back('{FUNC_DATA, k ? 8'h11 : BYTE_FF, 32'sh0, 1'b0, 64'h0, 4'd0});
			dir.push_back('{FUNC_DATA, 8'h22, 32'sh0, 1'b0, 64'h0, 4'd0});
			dir.push_back('{FUNC_DATA, 8'h33, 32'sh0, 1'b0, 64'h0, 4'd0});
		end
		dir.push_back('{FUNC_END, 8'h00, 32'sh0, 1'b0, 64'h0, 4'd0});

		foreach (dir[i]) begin
			r = dir[i];
			send_word(r.fn, r.db, r.off, 0);
			if (r.chk) begin
				if (expected_words.size() == 0 || expected_words[$].bytes !== r.xbytes
						|| expected_words[$].cnt !== r.xcnt) begin
					$error("directed row %0d: model expectation mismatch", i);
					errors++;
				end
			end
		end

		// long runs and literal chunk limits
		send_word(FUNC_START, 8'h00, 0, 0);
		repeat (70) send_word(FUNC_DATA, 8'h00, 0, 0);
		repeat (40) send_word(FUNC_DATA, 8'h5A, 0, 0);
		for (int i = 0; i < 130; i++)
			send_word(FUNC_DATA, 8'(i), 0, 0);
		repeat (4) send_word(FUNC_DATA, 8'h00, 0, 0);
		send_word(FUNC_DATA, BYTE_FF, 0, 0);
		send_word(FUNC_DATA, 8'h07, 0, 0);
		send_word(FUNC_END, 8'h00, 0, 0);

		// random ranges, then a stretch without receiver stalls
		for (int n = 0; n < 120; ) begin
			int len;
			len = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 15);
			send_random_range(len);
			n += len + 2;
			if (n > 90)
				rx_stall_on = 0;
		end
		send_word(FUNC_END, 8'h00, 0, 0);
		in_valid <= 0;

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: run_length_literal_byte_encoder_core.f
design/rllbe_pkg.sv
design/rllbe_lit_mem.sv
design/rllbe_pack.sv
design/rllbe_ctrl.sv
design/run_length_literal_byte_encoder_core.sv
test/testbench.sv
